// File: hw/rtl/mtp_pkg.sv
package mtp_pkg;

   localparam int unsigned StateWords  = 624;
   localparam int unsigned TwistOffset = 397;
   localparam int unsigned WordW       = 32;
   localparam int unsigned PosW        = $clog2(StateWords);
   localparam int unsigned CsrAddrW    = 3;

   localparam logic [WordW-1:0] SeedReset = 32'd5489;
   localparam logic [WordW-1:0] InitMult  = 32'd1812433253;
   localparam logic [WordW-1:0] MatrixA   = 32'h9908b0df;
   localparam logic [WordW-1:0] UpperMask = 32'h80000000;
   localparam logic [WordW-1:0] LowerMask = 32'h7fffffff;
   localparam logic [WordW-1:0] TemperB   = 32'h9d2c5680;
   localparam logic [WordW-1:0] TemperC   = 32'hefc60000;

   // Register index codes, taken from the word address bits above the byte offset.
   localparam logic CsrIdxSeed = 1'b0;

   typedef struct packed {
      logic             busy;
      logic             shift;
      logic [WordW-1:0] word;
   } mtp_fill_type;

   function automatic logic [WordW-1:0] mtp_twist(input logic [WordW-1:0] here,
                                                  input logic [WordW-1:0] nxt,
                                                  input logic [WordW-1:0] far);
      logic [WordW-1:0] y;
      y = (here & UpperMask) | (nxt & LowerMask);
      return far ^ (y >> 1) ^ (y[0] ? MatrixA : '0);
   endfunction

   function automatic logic [WordW-1:0] mtp_temper(input logic [WordW-1:0] word);
      logic [WordW-1:0] y;
      y = word;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TemperB);
      y = y ^ ((y << 15) & TemperC);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// File: hw/rtl/mtp_if.sv
interface mtp_req_if;
   logic valid;
   logic ready;
   logic request;

   modport source (output valid, output request, input ready);
   modport sink (input valid, input request, output ready);
endinterface

interface mtp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink (input valid, input random_word, output ready);
endinterface

// File: hw/rtl/mtp_cell.sv
module mtp_cell import mtp_pkg::*; (
   input  logic             clock,
   input  logic             shift_en,
   input  logic [WordW-1:0] shift_word,
   output logic [WordW-1:0] word
);

   logic [WordW-1:0] word_ff;
   logic [WordW-1:0] word_in;

   assign word_in = shift_en ? shift_word : word_ff;

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// File: hw/rtl/mtp_seed_fill.sv
module mtp_seed_fill import mtp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WordW-1:0] seed,
   input  logic [WordW-1:0] tail,
   output mtp_fill_type     fill
);

   localparam logic FillIdle = 1'b0;
   localparam logic FillRun  = 1'b1;

   logic            state_ff;
   logic            state_in;
   logic [PosW-1:0] fill_cnt_ff;
   logic [PosW-1:0] fill_cnt_in;
   logic            last_word;
   logic [WordW-1:0] mixed;
   logic [WordW-1:0] product;

   assign last_word = (fill_cnt_ff == PosW'(StateWords - 1));

   always_comb begin
      state_in    = state_ff;
      fill_cnt_in = fill_cnt_ff;
      case (state_ff)
         FillIdle: begin
            fill_cnt_in = '0;
         end
         FillRun: begin
            fill_cnt_in = fill_cnt_ff + 1'b1;
            if (last_word) begin
               state_in    = FillIdle;
               fill_cnt_in = '0;
            end
         end
         default: begin
            state_in    = FillIdle;
            fill_cnt_in = '0;
         end
      endcase
      if (start) begin
         state_in    = FillRun;
         fill_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FillRun;
         fill_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         fill_cnt_ff <= fill_cnt_in;
      end
   end

   // The tail cell holds the word shifted in on the previous cycle.
   assign mixed   = tail ^ (tail >> 30);
   assign product = WordW'(mixed * InitMult);

   assign fill.busy  = (state_ff == FillRun);
   assign fill.shift = (state_ff == FillRun);
   assign fill.word  = (fill_cnt_ff == '0) ? seed
                                           : product + {{(WordW - PosW){1'b0}}, fill_cnt_ff};

   assert property (@(posedge clock) disable iff (reset)
      fill_cnt_ff <= PosW'(StateWords - 1))
      else $error("fill counter ran past the table end");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FillIdle) |-> (fill_cnt_ff == '0))
      else $error("fill counter not cleared while idle");

endmodule

// File: hw/rtl/mtp_out_buf.sv
module mtp_out_buf import mtp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WordW-1:0] in_word,
   output logic             has_room,
   mtp_rsp_if.source        rsp
);

   logic             main_valid_ff;
   logic             main_valid_in;
   logic [WordW-1:0] main_word_ff;
   logic [WordW-1:0] main_word_in;
   logic             skid_valid_ff;
   logic             skid_valid_in;
   logic [WordW-1:0] skid_word_ff;
   logic [WordW-1:0] skid_word_in;
   logic             main_free;

   assign main_free = !main_valid_ff || rsp.ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_word_in  = main_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_word_in  = skid_word_ff;
            skid_valid_in = in_valid;
            skid_word_in  = in_word;
         end else begin
            main_valid_in = in_valid;
            main_word_in  = in_word;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_word_in  = in_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign has_room        = !skid_valid_ff;
   assign rsp.valid       = main_valid_ff;
   assign rsp.random_word = main_word_ff;

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage holds a word while the output stage is empty");

   assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !skid_valid_ff)
      else $error("word arrived with both output stages full");

endmodule

// File: hw/rtl/mersenne_twister_prng_unit.sv
// Channel   Dir  Payload                    Transaction when
// req_chan  in   request (1 bit)            valid && ready; request 0 yields no result
// rsp_chan  out  random_word (32 bits)      valid && ready
// csr_*     in   seed at byte address 0     psel && penable && pwrite (pready tied high)
//
// One word per clock: the state is a 624-cell shift line, and each request twists the
// head cells 0, 1 and 397 and shifts the new word into the tail in the same cycle.
// After reset and after every seed write the line is refilled, one word a cycle through
// the single multiplier of the seed recurrence; requests wait meanwhile.
// Results go through an output register and a skid stage, so one stalled word does not
// block the next request; a second stalled word does.
module mersenne_twister_prng_unit import mtp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   mtp_req_if.sink             req_chan,
   mtp_rsp_if.source           rsp_chan,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [WordW-1:0]    csr_pwdata,
   output logic [WordW-1:0]    csr_prdata,
   output logic                csr_pready
);

   logic [WordW-1:0] seed_ff;
   logic [WordW-1:0] seed_in;
   logic             seed_write;
   mtp_fill_type     fill;
   logic             has_room;
   logic             step_en;
   logic             shift_en;
   logic [WordW-1:0] twisted;
   logic [WordW-1:0] tail_word;
   logic [WordW-1:0] cell_word [StateWords];

   // Configuration port.
   assign csr_pready = 1'b1;
   assign seed_write = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == CsrIdxSeed);
   assign seed_in    = seed_write ? csr_pwdata : seed_ff;
   assign csr_prdata = (csr_paddr[2] == CsrIdxSeed) ? seed_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SeedReset;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mtp_seed_fill u_fill (
      .clock (clock),
      .reset (reset),
      .start (seed_write),
      .seed  (seed_ff),
      .tail  (cell_word[StateWords-1]),
      .fill  (fill)
   );

   // Request side.
   assign req_chan.ready = has_room && !fill.busy;
   assign step_en        = req_chan.valid && req_chan.ready && req_chan.request;

   assign twisted   = mtp_twist(cell_word[0], cell_word[1], cell_word[TwistOffset]);
   assign shift_en  = fill.shift || step_en;
   assign tail_word = fill.shift ? fill.word : twisted;

   // The head cell always holds the word at the current position.
   for (genvar i = 0; i < StateWords; i++) begin : g_cell
      if (i == StateWords - 1) begin : g_tail
         mtp_cell u_cell (
            .clock      (clock),
            .shift_en   (shift_en),
            .shift_word (tail_word),
            .word       (cell_word[i])
         );
      end else begin : g_body
         mtp_cell u_cell (
            .clock      (clock),
            .shift_en   (shift_en),
            .shift_word (cell_word[i+1]),
            .word       (cell_word[i])
         );
      end
   end

   mtp_out_buf u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (step_en),
      .in_word  (mtp_temper(twisted)),
      .has_room (has_room),
      .rsp      (rsp_chan)
   );

   assert property (@(posedge clock) disable iff (reset)
      fill.busy |-> !req_chan.ready)
      else $error("request taken while the state is being refilled");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(step_en))
      else $error("result appeared without a request transaction");

endmodule

// File: tb/sv/mtp_stream_checker.sv
module mtp_stream_checker import mtp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   mtp_req_if                  req_mon,
   mtp_rsp_if                  rsp_mon,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic                csr_pready,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [WordW-1:0]    csr_pwdata,
   input  logic                drain_done,
   output int                  mismatch_count,
   output int                  words_pending
);

   localparam int          TableWords  = 624;
   localparam int          FarOffset   = 397;
   localparam logic [31:0] DefaultSeed = 32'd5489;
   localparam logic [31:0] SeedMult    = 32'd1812433253;
   localparam logic [31:0] TwistMatrix = 32'h9908b0df;
   localparam logic [31:0] HighBit     = 32'h80000000;
   localparam logic [31:0] LowBits     = 32'h7fffffff;
   localparam logic [31:0] TemperMaskB = 32'h9d2c5680;
   localparam logic [31:0] TemperMaskC = 32'hefc60000;

   logic [31:0] mt_words [TableWords];
   int          twist_pos;
   logic [31:0] expected_words [$];
   int          results_seen;
   logic [31:0] oldest_word;

   initial begin
      mismatch_count = 0;
      words_pending  = 0;
      results_seen   = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic void load_seed_table(input logic [31:0] seed_word);
      logic [31:0] prev;
      mt_words[0] = seed_word;
      for (int k = 1; k < TableWords; k++) begin
         prev        = mt_words[k-1];
         mt_words[k] = SeedMult * (prev ^ (prev >> 30)) + 32'(k);
      end
      twist_pos = 0;
   endfunction

   // Twists the word at the current position in place and returns it tempered.
   function automatic logic [31:0] twist_next_word();
      int          here;
      int          nxt;
      int          far;
      logic [31:0] y;
      logic [31:0] t;
      here = twist_pos;
      nxt  = (here == TableWords - 1) ? 0 : here + 1;
      far  = here + FarOffset;
      if (far >= TableWords) begin
         far = far - TableWords;
      end
      y = (mt_words[here] & HighBit) | (mt_words[nxt] & LowBits);
      y = mt_words[far] ^ (y >> 1) ^ (y[0] ? TwistMatrix : 32'h0);
      mt_words[here] = y;
      twist_pos      = nxt;
      t = y ^ (y >> 11);
      t = t ^ ((t << 7) & TemperMaskB);
      t = t ^ ((t << 15) & TemperMaskC);
      t = t ^ (t >> 18);
      return t;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         load_seed_table(DefaultSeed);
         expected_words.delete();
      end else begin
         // Only the seed index refills the table; a write to any other index is dropped.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CsrAddrW-1:2] == CsrIdxSeed) begin
            load_seed_table(csr_pwdata);
         end
         if (req_mon.valid && req_mon.ready && req_mon.request) begin
            expected_words.push_back(twist_next_word());
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen++;
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected result transaction, random_word %h",
                                         rsp_mon.random_word));
            end else begin
               oldest_word = expected_words.pop_front();
               if (rsp_mon.random_word !== oldest_word) begin
                  report_mismatch($sformatf("result %0d: random_word %h, expected %h",
                                            results_seen, rsp_mon.random_word,
                                            oldest_word));
               end
            end
         end
         if (drain_done && expected_words.size() != 0) begin
            report_mismatch($sformatf("%0d expected words never delivered, oldest %h",
                                      expected_words.size(), expected_words[0]));
            expected_words.delete();
         end
      end
      words_pending = expected_words.size();
   end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
   import mtp_pkg::*;

   localparam logic [CsrAddrW-1:0] SeedAddr      = {CsrIdxSeed, 2'b00};
   localparam logic [CsrAddrW-1:0] SpareAddr     = {~CsrIdxSeed, 2'b00};
   localparam int                  SettleCycles  = 8;
   localparam int                  HoldOffCycles = 250;
   localparam int                  DrainLimit    = 5000;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [WordW-1:0]    csr_pwdata;
   logic [WordW-1:0]    csr_prdata;
   logic                csr_pready;
   logic                drain_done;
   int                  mismatch_count;
   int                  words_pending;
   int                  hold_off_asked;

   mtp_req_if req_bus ();
   mtp_rsp_if rsp_bus ();

   always #1 clock = ~clock;

   mersenne_twister_prng_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mtp_stream_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .drain_done     (drain_done),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   // Sends the given request bits in bursts of random length with random gaps.
   task automatic send_request_bits(input bit bits[$], input int max_gap);
      int burst_left;
      int gap;
      @(negedge clock);
      burst_left = $urandom_range(1, 24);
      foreach (bits[i]) begin
         req_bus.valid   <= 1'b1;
         req_bus.request <= bits[i];
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         @(negedge clock);
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, max_gap);
            if (gap > 0 && i != bits.size() - 1) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
      req_bus.valid <= 1'b0;
   endtask

   task automatic offer_random_requests(input int words, input int max_gap);
      bit bits[$];
      int ones;
      ones = 0;
      while (ones < words) begin
         if ($urandom_range(0, 7) == 0) begin
            bits.push_back(1'b0);
         end else begin
            bits.push_back(1'b1);
            ones++;
         end
      end
      send_request_bits(bits, max_gap);
   endtask

   // Idle-request transactions may still be in flight when the last word arrives,
   // so a few extra cycles pass before anything else happens.
   task automatic wait_idle();
      while (words_pending != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CsrAddrW-1:0] addr, input logic [WordW-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Receiver: rotates through stall modes, and holds off entirely when asked.
   initial begin : sink_proc
      int mode;
      int mode_left;
      int hold_left;
      int holds_served;
      mode         = 0;
      mode_left    = 0;
      hold_left    = 0;
      holds_served = 0;
      rsp_bus.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (holds_served != hold_off_asked) begin
            holds_served = hold_off_asked;
            hold_left    = HoldOffCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
               0: begin
                  rsp_bus.ready <= 1'b1;
               end
               1: begin
                  rsp_bus.ready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_bus.ready <= (mode_left % 4 != 0);
               end
            endcase
         end
      end
   end

   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus_proc
      bit directed_bits[$];
      int drain_cycles;
      reset           = 1'b1;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      drain_done      = 1'b0;
      hold_off_asked  = 0;
      req_bus.valid   = 1'b0;
      req_bus.request = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Reset seed, with an idle request mixed into the stream.
      directed_bits.delete();
      directed_bits.push_back(1'b1);
      directed_bits.push_back(1'b1);
      directed_bits.push_back(1'b0);
      directed_bits.push_back(1'b1);
      directed_bits.push_back(1'b1);
      send_request_bits(directed_bits, 0);

      wait_idle();
      csr_write(SeedAddr, 32'h0000_0000);
      directed_bits.delete();
      directed_bits.push_back(1'b1);
      directed_bits.push_back(1'b0);
      directed_bits.push_back(1'b1);
      directed_bits.push_back(1'b1);
      send_request_bits(directed_bits, 2);

      // A write to the unused index must leave the stream untouched.
      wait_idle();
      csr_write(SpareAddr, 32'hffff_ffff);
      directed_bits.delete();
      directed_bits.push_back(1'b1);
      directed_bits.push_back(1'b1);
      send_request_bits(directed_bits, 0);

      wait_idle();
      csr_write(SeedAddr, 32'hffff_ffff);
      directed_bits.delete();
      directed_bits.push_back(1'b1);
      directed_bits.push_back(1'b1);
      directed_bits.push_back(1'b1);
      send_request_bits(directed_bits, 1);

      wait_idle();
      csr_write(SeedAddr, 32'h0000_0001);
      directed_bits.delete();
      directed_bits.push_back(1'b0);
      directed_bits.push_back(1'b1);
      directed_bits.push_back(1'b1);
      directed_bits.push_back(1'b1);
      send_request_bits(directed_bits, 0);

      // Long run on one seed so the far index wraps.
      wait_idle();
      csr_write(SeedAddr, 32'($urandom));
      offer_random_requests(180, 6);
      hold_off_asked++;
      offer_random_requests(40, 1);
      wait_idle();
      offer_random_requests(100, 4);

      wait_idle();
      csr_write(SpareAddr, 32'($urandom));
      offer_random_requests(20, 3);

      wait_idle();
      csr_write(SeedAddr, SeedReset);
      offer_random_requests(20, 3);

      wait_idle();
      csr_write(SeedAddr, 32'($urandom));
      offer_random_requests(20, 10);

      drain_cycles = 0;
      while (words_pending != 0 && drain_cycles < DrainLimit) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (SettleCycles) @(negedge clock);
      drain_done <= 1'b1;
      repeat (2) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/mtp_pkg.sv
hw/rtl/mtp_if.sv
hw/rtl/mtp_cell.sv
hw/rtl/mtp_seed_fill.sv
hw/rtl/mtp_out_buf.sv
hw/rtl/mersenne_twister_prng_unit.sv
tb/sv/mtp_stream_checker.sv
tb/sv/tb_top.sv
